>>> rtl/vty_pkg.sv
package vty_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int COORD_W      = 32;
    localparam int VEC_W        = 33;
    localparam int GUARD_BITS   = 24;
    localparam int CORDIC_W     = 60;
    localparam int ANG_W        = 64;
    localparam int RAD_W        = 33;
    localparam int CORDIC_ITERS = 48;
    localparam int SQRT_STEPS   = 32;
    localparam int YAW_W        = 25;
    localparam int PITCH_W      = 24;
    localparam int DEG_SHIFT    = 54;
    localparam logic signed [31:0] DEG_PER_RAD_Q24 = 32'sd961263669;

    // Shift-subtract long division, evaluated at elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/n) in Q.60 by its alternating series
    function automatic logic [63:0] atan_inv_q60(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] n2;
        p   = udiv64(64'd1 << 60, n);
        sum = '0;
        n2  = n * n;
        for (int k = 0; k < 64; k++)
        begin
            if (p != '0)
            begin
                term = udiv64(p, 64'(2 * k + 1));
                if ((k & 1) == 0)
                    sum = sum + term;
                else
                    sum = sum - term;
                p = udiv64(p, n2);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] quarter_pi_q60();
        return (atan_inv_q60(64'd5) << 2) - atan_inv_q60(64'd239);
    endfunction

    localparam logic [63:0] PI_Q60 = quarter_pi_q60() << 2;

    // atan(2^-i) in Q.60
    function automatic logic [63:0] atan_entry(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum = '0;
        if (i == 0)
            return quarter_pi_q60();
        for (int k = 0; k < 32; k++)
        begin
            e = 60 - i * (2 * k + 1);
            if (e >= 0)
            begin
                term = udiv64(64'd1 << e, 64'(2 * k + 1));
                if ((k & 1) == 0)
                    sum = sum + term;
                else
                    sum = sum - term;
            end
        end
        return sum;
    endfunction

endpackage

>>> rtl/vty_cordic.sv
module vty_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [vty_pkg::VEC_W-1:0]    a_in,
    input  logic signed [vty_pkg::VEC_W-1:0]    b_in,
    output logic signed [vty_pkg::ANG_W-1:0]    ang
);

    localparam int N   = vty_pkg::CORDIC_ITERS;
    localparam int CW  = vty_pkg::CORDIC_W;
    localparam int AW  = vty_pkg::ANG_W;
    localparam int GB  = vty_pkg::GUARD_BITS;
    localparam int PAD = CW - vty_pkg::VEC_W - GB;
    localparam logic signed [AW-1:0] PI = vty_pkg::PI_Q60;

    logic signed [CW-1:0] a_ext;
    logic signed [CW-1:0] b_ext;
    logic signed [CW-1:0] a_next;
    logic signed [CW-1:0] b_next;
    logic signed [AW-1:0] z_next;

    logic signed [CW-1:0] a_reg [N+1];
    logic signed [CW-1:0] b_reg [N+1];
    logic signed [AW-1:0] z_reg [N+1];

    assign a_ext = {{PAD{a_in[vty_pkg::VEC_W-1]}}, a_in, {GB{1'b0}}};
    assign b_ext = {{PAD{b_in[vty_pkg::VEC_W-1]}}, b_in, {GB{1'b0}}};

    // Fold the left half plane into the right half by a half turn.
    always_comb
    begin
        if (a_ext[CW-1])
        begin
            a_next = -a_ext;
            b_next = -b_ext;
            z_next = b_ext[CW-1] ? -PI : PI;
        end
        else
        begin
            a_next = a_ext;
            b_next = b_ext;
            z_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= a_next;
            b_reg[0] <= b_next;
            z_reg[0] <= z_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam logic signed [AW-1:0] ATAN = vty_pkg::atan_entry(i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!b_reg[i][CW-1])
                begin
                    a_reg[i+1] <= a_reg[i] + (b_reg[i] >>> i);
                    b_reg[i+1] <= b_reg[i] - (a_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                else
                begin
                    a_reg[i+1] <= a_reg[i] - (b_reg[i] >>> i);
                    b_reg[i+1] <= b_reg[i] + (a_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
            end
        end
    end

    assign ang = z_reg[N];

endmodule

>>> rtl/vector_to_yaw_pitch.sv
// Throughput: one vector per cycle; a stalled ang beat freezes every stage.
// The pipeline depth is set by the 32-step square root ahead of the two 48-stage CORDICs,
// which run side by side.
// Reset (rst_n, async, active low) clears the stage valid bits and ang_valid;
// pipeline data is not reset.
module vector_to_yaw_pitch #(
    parameter int FRAC_BITS = vty_pkg::FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    vec_valid,
    output logic                                    vec_ready,
    input  logic signed [vty_pkg::COORD_W-1:0]      x_coord,
    input  logic signed [vty_pkg::COORD_W-1:0]      y_coord,
    input  logic signed [vty_pkg::COORD_W-1:0]      z_coord,
    output logic                                    ang_valid,
    input  logic                                    ang_ready,
    output logic        [vty_pkg::YAW_W-1:0]        yaw_angle,
    output logic signed [vty_pkg::PITCH_W-1:0]      pitch_angle
);

    localparam int CW     = vty_pkg::COORD_W;
    localparam int VW     = vty_pkg::VEC_W;
    localparam int AW     = vty_pkg::ANG_W;
    localparam int RW     = vty_pkg::RAD_W;
    localparam int SH_W   = $clog2(CW);
    localparam int SQ_W   = 2 * CW;
    localparam int SQ_N   = vty_pkg::SQRT_STEPS;
    localparam int ITERS  = vty_pkg::CORDIC_ITERS;
    localparam int SIDE_N = SQ_N + ITERS + 9;
    localparam int CAR_N  = SQ_N + 2;
    localparam int DEG_W  = FRAC_BITS + 10;
    localparam int RND_SH = vty_pkg::DEG_SHIFT - FRAC_BITS;
    localparam int EXT_W  = ((DEG_W > vty_pkg::YAW_W) ? DEG_W : vty_pkg::YAW_W) + 1;

    localparam logic signed [AW-1:0]    RAD_HALF   = 64'sd1 <<< 29;
    localparam logic signed [AW-1:0]    DEG_HALF   = 64'sd1 <<< (RND_SH - 1);
    localparam logic signed [EXT_W-1:0] FULL       = EXT_W'(360) << FRAC_BITS;
    localparam logic signed [EXT_W-1:0] NINETY     = EXT_W'(90) << FRAC_BITS;
    localparam logic signed [EXT_W-1:0] NEG_NINETY = -NINETY;

    typedef struct packed {
        logic valid;
        logic zero_xy;
        logic z_pos;
        logic z_neg;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] xn1;
        logic signed [CW-1:0] yn1;
        logic signed [CW-1:0] zn2;
    } car_t;

    function automatic logic [SH_W-1:0] norm_shift(input logic [CW-1:0] m);
        logic [SH_W-1:0] s;
        s = '0;
        for (int k = 0; k < CW; k++)
        begin
            if (m[k])
                s = (k >= CW - 2) ? '0 : SH_W'(CW - 2 - k);
        end
        return s;
    endfunction

    logic en;

    side_t side_next;
    side_t side_reg [SIDE_N];
    logic  out_valid_reg;

    logic [CW-1:0] ax_in;
    logic [CW-1:0] ay_in;
    logic [CW-1:0] az_in;
    logic [CW-1:0] mxy_next;
    logic [CW-1:0] mall_next;

    logic signed [CW-1:0] x1_reg;
    logic signed [CW-1:0] y1_reg;
    logic signed [CW-1:0] z1_reg;
    logic        [CW-1:0] m1_reg;
    logic        [CW-1:0] m2_reg;

    logic signed [CW-1:0] x2_reg;
    logic signed [CW-1:0] y2_reg;
    logic signed [CW-1:0] z2_reg;
    logic [SH_W-1:0]      s1_reg;
    logic [SH_W-1:0]      s2_reg;

    logic signed [CW-1:0] xs2;
    logic signed [CW-1:0] ys2;
    logic signed [CW-1:0] xn1_reg;
    logic signed [CW-1:0] yn1_reg;
    logic signed [CW-1:0] zn2_reg;
    logic        [CW-1:0] ax3_reg;
    logic        [CW-1:0] ay3_reg;

    logic [SQ_W-1:0] sqx_reg;
    logic [SQ_W-1:0] sqy_reg;
    car_t            car_reg [CAR_N];

    logic [SQ_W-1:0] sqv_reg [SQ_N];
    logic [SQ_W-1:0] sqr_reg [SQ_N+1];

    logic signed [VW-1:0] yaw_a;
    logic signed [VW-1:0] yaw_b;
    logic signed [VW-1:0] pitch_a;
    logic signed [VW-1:0] pitch_b;
    logic signed [AW-1:0] yaw_rad;
    logic signed [AW-1:0] pitch_rad;

    logic signed [AW-1:0] yaw_rsum;
    logic signed [AW-1:0] pitch_rsum;
    logic signed [RW-1:0] yaw_r30_reg;
    logic signed [RW-1:0] pitch_r30_reg;

    logic signed [AW-1:0] yaw_d54_next;
    logic signed [AW-1:0] pitch_d54_next;
    logic signed [AW-1:0] yaw_d54_reg;
    logic signed [AW-1:0] pitch_d54_reg;

    logic signed [AW-1:0]    yaw_dsum;
    logic signed [AW-1:0]    pitch_dsum;
    logic signed [DEG_W-1:0] yaw_deg_reg;
    logic signed [DEG_W-1:0] pitch_deg_reg;

    logic signed [EXT_W-1:0]      yaw_ext;
    logic signed [EXT_W-1:0]      yaw_wrap;
    logic signed [EXT_W-1:0]      yaw_fin;
    logic signed [EXT_W-1:0]      pitch_ext;
    logic signed [EXT_W-1:0]      pitch_fin;
    logic [vty_pkg::YAW_W-1:0]    yaw_angle_next;
    logic [vty_pkg::PITCH_W-1:0]  pitch_angle_next;
    logic [vty_pkg::YAW_W-1:0]    yaw_angle_reg;
    logic [vty_pkg::PITCH_W-1:0]  pitch_angle_reg;

    // Whole pipeline advances together; the output register frees on a taken beat.
    assign en        = !out_valid_reg || ang_ready;
    assign vec_ready = en;
    assign ang_valid = out_valid_reg;

    always_comb
    begin
        side_next.valid   = vec_valid;
        side_next.zero_xy = (x_coord == '0) && (y_coord == '0);
        side_next.z_pos   = !z_coord[CW-1] && (z_coord != '0);
        side_next.z_neg   = z_coord[CW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SIDE_N; k++)
                side_reg[k] <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < SIDE_N; k++)
                side_reg[k] <= side_reg[k-1];
            out_valid_reg <= side_reg[SIDE_N-1].valid;
        end
    end

    // Magnitudes; the most negative input maps to 2^31, which still fits unsigned.
    assign ax_in     = x_coord[CW-1] ? (~x_coord + CW'(1'b1)) : x_coord;
    assign ay_in     = y_coord[CW-1] ? (~y_coord + CW'(1'b1)) : y_coord;
    assign az_in     = z_coord[CW-1] ? (~z_coord + CW'(1'b1)) : z_coord;
    assign mxy_next  = (ax_in > ay_in) ? ax_in : ay_in;
    assign mall_next = (az_in > mxy_next) ? az_in : mxy_next;

    assign xs2 = x2_reg <<< s2_reg;
    assign ys2 = y2_reg <<< s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x_coord;
            y1_reg  <= y_coord;
            z1_reg  <= z_coord;
            m1_reg  <= mxy_next;
            m2_reg  <= mall_next;

            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            s1_reg  <= norm_shift(m1_reg);
            s2_reg  <= norm_shift(m2_reg);

            xn1_reg <= x2_reg <<< s1_reg;
            yn1_reg <= y2_reg <<< s1_reg;
            zn2_reg <= z2_reg <<< s2_reg;
            ax3_reg <= xs2[CW-1] ? (~xs2 + CW'(1'b1)) : xs2;
            ay3_reg <= ys2[CW-1] ? (~ys2 + CW'(1'b1)) : ys2;

            sqx_reg <= SQ_W'(ax3_reg) * SQ_W'(ax3_reg);
            sqy_reg <= SQ_W'(ay3_reg) * SQ_W'(ay3_reg);
            car_reg[0] <= '{xn1: xn1_reg, yn1: yn1_reg, zn2: zn2_reg};

            sqv_reg[0] <= sqx_reg + sqy_reg;
            sqr_reg[0] <= '0;
            for (int k = 1; k < CAR_N; k++)
                car_reg[k] <= car_reg[k-1];
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);

        logic [SQ_W:0] trial;

        assign trial = {1'b0, sqr_reg[k]} + {1'b0, BIT};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, sqv_reg[k]} >= trial)
                    sqr_reg[k+1] <= (sqr_reg[k] >> 1) + BIT;
                else
                    sqr_reg[k+1] <= sqr_reg[k] >> 1;
            end
        end

        if (k < SQ_N - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if ({1'b0, sqv_reg[k]} >= trial)
                        sqv_reg[k+1] <= sqv_reg[k] - trial[SQ_W-1:0];
                    else
                        sqv_reg[k+1] <= sqv_reg[k];
                end
            end
        end
    end

    assign yaw_a   = {car_reg[CAR_N-1].xn1[CW-1], car_reg[CAR_N-1].xn1};
    assign yaw_b   = {car_reg[CAR_N-1].yn1[CW-1], car_reg[CAR_N-1].yn1};
    assign pitch_a = {1'b0, sqr_reg[SQ_N][CW-1:0]};
    assign pitch_b = -{car_reg[CAR_N-1].zn2[CW-1], car_reg[CAR_N-1].zn2};

    vty_cordic u_yaw_cordic (
        .clk  (clk),
        .en   (en),
        .a_in (yaw_a),
        .b_in (yaw_b),
        .ang  (yaw_rad)
    );

    vty_cordic u_pitch_cordic (
        .clk  (clk),
        .en   (en),
        .a_in (pitch_a),
        .b_in (pitch_b),
        .ang  (pitch_rad)
    );

    // Radians Q.60 -> Q.30 -> degrees Q.54 -> degrees with FRAC_BITS fraction
    assign yaw_rsum       = yaw_rad + RAD_HALF;
    assign pitch_rsum     = pitch_rad + RAD_HALF;
    assign yaw_d54_next   = AW'(yaw_r30_reg) * AW'(vty_pkg::DEG_PER_RAD_Q24);
    assign pitch_d54_next = AW'(pitch_r30_reg) * AW'(vty_pkg::DEG_PER_RAD_Q24);
    assign yaw_dsum       = yaw_d54_reg + DEG_HALF;
    assign pitch_dsum     = pitch_d54_reg + DEG_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_r30_reg   <= yaw_rsum[30 +: RW];
            pitch_r30_reg <= pitch_rsum[30 +: RW];
            yaw_d54_reg   <= yaw_d54_next;
            pitch_d54_reg <= pitch_d54_next;
            yaw_deg_reg   <= yaw_dsum[RND_SH +: DEG_W];
            pitch_deg_reg <= pitch_dsum[RND_SH +: DEG_W];
        end
    end

    assign yaw_ext   = {{(EXT_W-DEG_W){yaw_deg_reg[DEG_W-1]}}, yaw_deg_reg};
    assign pitch_ext = {{(EXT_W-DEG_W){pitch_deg_reg[DEG_W-1]}}, pitch_deg_reg};

    always_comb
    begin
        yaw_wrap = yaw_ext[EXT_W-1] ? (yaw_ext + FULL) : yaw_ext;
        yaw_fin  = (yaw_wrap >= FULL) ? (yaw_wrap - FULL) : yaw_wrap;

        if (pitch_ext > NINETY)
            pitch_fin = NINETY;
        else if (pitch_ext < NEG_NINETY)
            pitch_fin = NEG_NINETY;
        else
            pitch_fin = pitch_ext;

        // Vector on the z axis: no heading, pitch straight up or down, or zero at the origin.
        if (side_reg[SIDE_N-1].zero_xy)
        begin
            yaw_fin = '0;
            if (side_reg[SIDE_N-1].z_pos)
                pitch_fin = NEG_NINETY;
            else if (side_reg[SIDE_N-1].z_neg)
                pitch_fin = NINETY;
            else
                pitch_fin = '0;
        end

        yaw_angle_next   = yaw_fin[vty_pkg::YAW_W-1:0];
        pitch_angle_next = pitch_fin[vty_pkg::PITCH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_angle_reg   <= yaw_angle_next;
            pitch_angle_reg <= pitch_angle_next;
        end
    end

    assign yaw_angle   = yaw_angle_reg;
    assign pitch_angle = pitch_angle_reg;

endmodule
